### hw/rtl/thm8_pkg.sv
package thm8_pkg;

  localparam int IDLE_H = 1200;
  localparam int IDLE_V = 1200;
  localparam int CLIP_H = 200;
  localparam int CLIP_V = 200;

  localparam int TERM_W = 21;   // Q.6 axis term
  localparam int SUM_W  = 23;   // three terms summed
  localparam int SPD_W  = 12;
  localparam logic [11:0] SPD_MAX = 12'hfff;

  localparam logic signed [SUM_W-1:0] LIM_H  = SUM_W'(CLIP_H * 64);
  localparam logic signed [SUM_W-1:0] LIM_V  = SUM_W'(CLIP_V * 64);
  localparam logic signed [SUM_W-1:0] BASE_H = SUM_W'(IDLE_H * 64);
  localparam logic signed [SUM_W-1:0] BASE_V = SUM_W'(IDLE_V * 64);

  // register indexes (word address)
  localparam logic [2:0] REG_BALANCE   = 3'd0;
  localparam logic [2:0] REG_SURGE     = 3'd1;
  localparam logic [2:0] REG_SWAY      = 3'd2;
  localparam logic [2:0] REG_HEAVE     = 3'd3;
  localparam logic [2:0] REG_ROLL      = 3'd4;
  localparam logic [2:0] REG_PITCH     = 3'd5;
  localparam logic [2:0] REG_YAW       = 3'd6;
  localparam logic [2:0] REG_STABILISE = 3'd7;

  localparam logic FUNC_ATTITUDE = 1'b0;
  localparam logic FUNC_COMMAND  = 1'b1;

  typedef struct packed {
    logic        balancing_mode;
    logic [15:0] gain_surge;
    logic [15:0] gain_sway;
    logic [15:0] gain_heave;
    logic [15:0] gain_roll;
    logic [15:0] gain_pitch;
    logic [15:0] gain_yaw;
    logic [15:0] gain_stabilise;
  } cfg_t;

  typedef struct packed {
    logic               func;
    logic signed [15:0] lin_surge;
    logic signed [15:0] lin_sway;
    logic signed [15:0] lin_heave;
    logic signed [15:0] rate_roll;
    logic signed [15:0] rate_pitch;
    logic signed [15:0] rate_yaw;
    logic signed [15:0] meas_roll;
    logic signed [15:0] meas_pitch;
  } item_t;

  typedef struct packed {
    logic signed [TERM_W-1:0] x;
    logic signed [TERM_W-1:0] y;
    logic signed [TERM_W-1:0] z;
    logic signed [TERM_W-1:0] r;
    logic signed [TERM_W-1:0] p;
    logic signed [TERM_W-1:0] w;
  } terms_t;

  // floor(v * g / 2^12)
  function automatic logic signed [TERM_W-1:0] cmd_term(logic signed [15:0] v,
                                                        logic [15:0] g);
    logic signed [33:0] prod;
    prod = signed'({v[15], v}) * signed'({1'b0, g});
    return signed'(prod[32:12]);
  endfunction

  // -floor(a * g / 2^13)
  function automatic logic signed [TERM_W-1:0] stab_term(logic signed [15:0] a,
                                                         logic [15:0] g);
    logic signed [33:0] prod;
    logic signed [TERM_W-1:0] fl;
    prod = signed'({a[15], a}) * signed'({1'b0, g});
    fl = TERM_W'(signed'(prod[32:13]));
    return -fl;
  endfunction

  // clamp, add idle, floor to rpm, saturate to the output range
  function automatic logic [SPD_W-1:0] drive(logic signed [SUM_W-1:0] s,
                                             logic signed [SUM_W-1:0] lim,
                                             logic signed [SUM_W-1:0] base);
    logic signed [SUM_W-1:0] c;
    logic signed [SUM_W-1:0] v;
    logic signed [SUM_W-7:0] rpm;
    if (s > lim) c = lim;
    else if (s < -lim) c = -lim;
    else c = s;
    v = c + base;
    rpm = signed'(v[SUM_W-1:6]);
    if (rpm < 0) return '0;
    else if (rpm > signed'((SUM_W-6)'(SPD_MAX))) return SPD_MAX;
    else return rpm[SPD_W-1:0];
  endfunction

endpackage

### hw/rtl/thruster_mixer_8_core.sv
// Channel   Dir  Handshake         Payload
// s_axis    in   s_tvalid/tready   s_tdata: 8 x 16-bit command/angle fields, s_tuser: func
// m_axis    out  m_tvalid/tready   m_tdata: 8 x 12-bit motor speeds
// apb       in   psel/penable      8 gain/mode registers, word addressed
//
// One item per cycle while m_tready is high. Stages: input register,
// registered multiply (six 16x17 products), then mix/clamp into the output register.
// Attitude items update the stored angles as they leave the input register and
// produce no transfer on m_axis. Reset clears all valid flags and the stored
// angles and loads the register defaults. m_tready low stalls each stage in turn.
module thruster_mixer_8_core (
  input  logic          clk,
  input  logic          rst,
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [4:0]    paddr,
  input  logic [31:0]   pwdata,
  output logic [31:0]   prdata,
  output logic          pready,
  input  logic          s_tvalid,
  output logic          s_tready,
  // lin_surge, lin_sway, lin_heave, rate_roll, rate_pitch, rate_yaw,
  // meas_roll, meas_pitch (16 bits each, from bit 0 up)
  input  logic [127:0]  s_tdata,
  // func
  input  logic          s_tuser,
  output logic          m_tvalid,
  input  logic          m_tready,
  // motor_h_front_right, motor_h_front_left, motor_h_back_right,
  // motor_h_back_left, motor_v_front_right, motor_v_front_left,
  // motor_v_back_right, motor_v_back_left (12 bits each, from bit 0 up)
  output logic [95:0]   m_tdata
);
  import thm8_pkg::*;

  cfg_t   cfg;
  item_t  in_item;
  terms_t terms;
  logic   t_valid;
  logic   t_ready;

  assign in_item.func       = s_tuser;
  assign in_item.lin_surge  = signed'(s_tdata[15:0]);
  assign in_item.lin_sway   = signed'(s_tdata[31:16]);
  assign in_item.lin_heave  = signed'(s_tdata[47:32]);
  assign in_item.rate_roll  = signed'(s_tdata[63:48]);
  assign in_item.rate_pitch = signed'(s_tdata[79:64]);
  assign in_item.rate_yaw   = signed'(s_tdata[95:80]);
  assign in_item.meas_roll  = signed'(s_tdata[111:96]);
  assign in_item.meas_pitch = signed'(s_tdata[127:112]);

  thm8_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  thm8_scale u_scale (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .in_item  (in_item),
    .t_valid  (t_valid),
    .t_ready  (t_ready),
    .terms    (terms)
  );

  thm8_mix u_mix (
    .clk       (clk),
    .rst       (rst),
    .t_valid   (t_valid),
    .t_ready   (t_ready),
    .terms     (terms),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (m_tdata)
  );

endmodule

### hw/rtl/thm8_regs.sv
module thm8_regs (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [4:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready,
  output thm8_pkg::cfg_t       cfg
);
  import thm8_pkg::*;

  logic       wr;
  logic [2:0] idx;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;
  assign idx    = paddr[4:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.balancing_mode <= 1'b0;
      cfg.gain_surge     <= 16'd12800;
      cfg.gain_sway      <= 16'd12800;
      cfg.gain_heave     <= 16'd12800;
      cfg.gain_roll      <= 16'd12800;
      cfg.gain_pitch     <= 16'd12800;
      cfg.gain_yaw       <= 16'd12800;
      cfg.gain_stabilise <= 16'd16306;
    end else if (wr) begin
      unique case (idx)
        REG_BALANCE:   cfg.balancing_mode <= pwdata[0];
        REG_SURGE:     cfg.gain_surge     <= pwdata[15:0];
        REG_SWAY:      cfg.gain_sway      <= pwdata[15:0];
        REG_HEAVE:     cfg.gain_heave     <= pwdata[15:0];
        REG_ROLL:      cfg.gain_roll      <= pwdata[15:0];
        REG_PITCH:     cfg.gain_pitch     <= pwdata[15:0];
        REG_YAW:       cfg.gain_yaw       <= pwdata[15:0];
        REG_STABILISE: cfg.gain_stabilise <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_BALANCE:   prdata = {31'd0, cfg.balancing_mode};
      REG_SURGE:     prdata = {16'd0, cfg.gain_surge};
      REG_SWAY:      prdata = {16'd0, cfg.gain_sway};
      REG_HEAVE:     prdata = {16'd0, cfg.gain_heave};
      REG_ROLL:      prdata = {16'd0, cfg.gain_roll};
      REG_PITCH:     prdata = {16'd0, cfg.gain_pitch};
      REG_YAW:       prdata = {16'd0, cfg.gain_yaw};
      REG_STABILISE: prdata = {16'd0, cfg.gain_stabilise};
      default:       prdata = '0;
    endcase
  end

endmodule

### hw/rtl/thm8_scale.sv
module thm8_scale (
  input  logic             clk,
  input  logic             rst,
  input  thm8_pkg::cfg_t   cfg,
  input  logic             in_valid,
  output logic             in_ready,
  input  thm8_pkg::item_t  in_item,
  output logic             t_valid,
  input  logic             t_ready,
  output thm8_pkg::terms_t terms
);
  import thm8_pkg::*;

  logic               s1_valid;
  item_t              s1;
  logic               s2_en;
  logic               s1_en;
  logic signed [15:0] stored_roll;
  logic signed [15:0] stored_pitch;
  terms_t             terms_next;

  assign s2_en    = !t_valid || t_ready;
  assign s1_en    = !s1_valid || s2_en;
  assign in_ready = s1_en;

  always_comb begin
    terms_next.x = cmd_term(s1.lin_surge, cfg.gain_surge);
    terms_next.y = cmd_term(s1.lin_sway, cfg.gain_sway);
    terms_next.z = cmd_term(s1.lin_heave, cfg.gain_heave);
    terms_next.w = cmd_term(s1.rate_yaw, cfg.gain_yaw);
    if (cfg.balancing_mode) begin
      terms_next.r = stab_term(stored_roll, cfg.gain_stabilise);
      terms_next.p = stab_term(stored_pitch, cfg.gain_stabilise);
    end else begin
      terms_next.r = cmd_term(s1.rate_roll, cfg.gain_roll);
      terms_next.p = cmd_term(s1.rate_pitch, cfg.gain_pitch);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid     <= 1'b0;
      t_valid      <= 1'b0;
      stored_roll  <= '0;
      stored_pitch <= '0;
    end else begin
      if (s1_en) s1_valid <= in_valid;
      if (s2_en) begin
        t_valid <= s1_valid && (s1.func == FUNC_COMMAND);
        // attitude is taken in item order, as it leaves the input stage
        if (s1_valid && (s1.func == FUNC_ATTITUDE)) begin
          stored_roll  <= s1.meas_roll;
          stored_pitch <= s1.meas_pitch;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_en && in_valid) s1 <= in_item;
    if (s2_en) terms <= terms_next;
  end

endmodule

### hw/rtl/thm8_mix.sv
module thm8_mix (
  input  logic             clk,
  input  logic             rst,
  input  logic             t_valid,
  output logic             t_ready,
  input  thm8_pkg::terms_t terms,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [95:0]      out_data
);
  import thm8_pkg::*;

  logic signed [SUM_W-1:0] x, y, z, r, p, w;
  logic [95:0]             out_data_next;

  assign t_ready = !out_valid || out_ready;

  always_comb begin
    x = SUM_W'(terms.x);
    y = SUM_W'(terms.y);
    z = SUM_W'(terms.z);
    r = SUM_W'(terms.r);
    p = SUM_W'(terms.p);
    w = SUM_W'(terms.w);
    out_data_next[11:0]  = drive(x - y + w, LIM_H, BASE_H);
    out_data_next[23:12] = drive(x + y - w, LIM_H, BASE_H);
    out_data_next[35:24] = drive(-x - y + w, LIM_H, BASE_H);
    out_data_next[47:36] = drive(-x + y - w, LIM_H, BASE_H);
    out_data_next[59:48] = drive(-z + r + p, LIM_V, BASE_V);
    out_data_next[71:60] = drive(-z - r + p, LIM_V, BASE_V);
    out_data_next[83:72] = drive(-z + r - p, LIM_V, BASE_V);
    out_data_next[95:84] = drive(-z - r - p, LIM_V, BASE_V);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (t_ready) begin
      out_valid <= t_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (t_ready && t_valid) out_data <= out_data_next;
  end

endmodule

### hw/rtl/thm8_checker.sv
module thm8_checker (
  input logic         clk,
  input logic         rst,
  input logic         s_tready,
  input logic         m_tvalid,
  input logic         m_tready,
  input logic [95:0]  m_tdata
);
  import thm8_pkg::*;

  // output stall must hold the transfer
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("m_axis transfer dropped or changed while stalled");

  a_rst_empty: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("m_tvalid high after reset");

  // empty output register means the whole pipe can move
  a_ready: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready)
    else $error("s_tready low with empty output");

  a_clamp: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[11:0] >= 12'(IDLE_H - CLIP_H)) &&
                 (m_tdata[11:0] <= 12'(IDLE_H + CLIP_H)) &&
                 (m_tdata[59:48] >= 12'(IDLE_V - CLIP_V)) &&
                 (m_tdata[59:48] <= 12'(IDLE_V + CLIP_V)))
    else $error("motor speed outside idle +/- clip");

  // front right and back left horizontal sums are negatives of each other
  a_sym: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> ((13'(m_tdata[11:0]) + 13'(m_tdata[47:36])) == 13'(2 * IDLE_H)) ||
                 ((13'(m_tdata[11:0]) + 13'(m_tdata[47:36])) == 13'(2 * IDLE_H - 1)))
    else $error("horizontal pair not symmetric about idle");

endmodule

bind thruster_mixer_8_core thm8_checker u_thm8_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
